[sv/clustered_hash_table_replacement_defines.svh]
`ifndef CLUSTERED_HASH_TABLE_REPLACEMENT_DEFINES_SVH
`define CLUSTERED_HASH_TABLE_REPLACEMENT_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define CHTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define CHTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/chtr_pkg.sv]
package chtr_pkg;

    localparam int MAX_CLUSTERS = 1024;
    localparam int WAYS         = 4;

    localparam int CLUSTER_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int HALF_W  = 32;
    localparam int ENTRY_W = KEY_W + DATA_W;
    localparam int ROW_W   = WAYS * ENTRY_W;

    localparam int MOVE_W  = 16;
    localparam int VALUE_W = 16;
    localparam int EVAL_W  = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int GEN_W   = 6;
    localparam int CC_W    = 11;

    localparam int MOVE_LSB  = 0;
    localparam int DEPTH_LSB = 48;
    localparam int GEN_LSB   = 58;

    localparam int MUL_W   = HALF_W + CC_W;
    localparam int SUM_W   = MUL_W + 1;
    localparam int WORTH_W = GEN_W + 5;

    localparam int CC_MAX = (1 << CC_W) - 1;
    localparam logic [CC_W-1:0] CC_LIMIT =
        CC_W'((MAX_CLUSTERS < CC_MAX) ? MAX_CLUSTERS : CC_MAX);
    localparam logic [CC_W-1:0] CC_RESET = CC_W'(1024);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CC_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLUSTER_COUNT = 1'b0,
        REG_GENERATION    = 1'b1
    } cfg_reg_t;

    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

    // Worth is depth less eight times the age relative to the current generation.
    function automatic logic signed [WORTH_W-1:0] entry_worth(
        input logic [DATA_W-1:0] d,
        input logic [GEN_W-1:0]  gen
    );
        logic [GEN_W-1:0]          age;
        logic signed [WORTH_W-1:0] dep;
        logic signed [WORTH_W-1:0] pen;
        age = gen - d[GEN_LSB +: GEN_W];
        dep = WORTH_W'(signed'(d[DEPTH_LSB +: DEPTH_W]));
        pen = signed'(WORTH_W'({age, 3'b000}));
        return dep - pen;
    endfunction

endpackage

[sv/clustered_hash_table_replacement.sv]
// Flow: a request is captured, then its cluster row is read; at commit the result is
// registered and a store writes the updated row back. Commit waits for a free output
// register. No new request is taken until the last is committed; in_stall is registered.
// Reset: asynchronous and active low; afterwards all 1024 clusters of the table are cleared
// one cluster a cycle, during which in_stall stays high and configuration is taken.
module clustered_hash_table_replacement
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic [chtr_pkg::KEY_W-1:0]             key,
    input  logic signed [chtr_pkg::DEPTH_W-1:0]    depth,
    input  logic signed [chtr_pkg::VALUE_W-1:0]    value,
    input  logic signed [chtr_pkg::EVAL_W-1:0]     eval,
    input  logic [chtr_pkg::MOVE_W-1:0]            move,
    input  logic [chtr_pkg::BOUND_W-1:0]           bound,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   hit,
    output logic [chtr_pkg::MOVE_W-1:0]            found_move,
    output logic signed [chtr_pkg::VALUE_W-1:0]    found_value,
    output logic signed [chtr_pkg::EVAL_W-1:0]     found_eval,
    output logic signed [chtr_pkg::DEPTH_W-1:0]    found_depth,
    output logic [chtr_pkg::BOUND_W-1:0]           found_bound,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [chtr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [chtr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    chtr_pkg::cmd_t    cmd;
    chtr_pkg::status_t status;

    chtr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    chtr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .key         (key),
        .depth       (depth),
        .value       (value),
        .eval        (eval),
        .move        (move),
        .bound       (bound),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .found_move  (found_move),
        .found_value (found_value),
        .found_eval  (found_eval),
        .found_depth (found_depth),
        .found_bound (found_bound)
    );

endmodule

[sv/chtr_ctrl.sv]
`include "clustered_hash_table_replacement_defines.svh"

module chtr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  chtr_pkg::status_t status,
    output chtr_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_INDEX;
                end
            end
            S_INDEX:
            begin
                cmd.read   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

    `CHTR_ASSERT_NOW(a_commit_needs_room, cmd.commit, status.out_free, "result committed into a full output register")
    `CHTR_ASSERT_NEXT(a_capture_then_read, cmd.capture, cmd.read, "cluster read does not follow a captured request")
    `CHTR_ASSERT_NOW(a_stall_while_busy, state_reg != S_IDLE, in_stall, "request taken while busy")

endmodule

[sv/chtr_datapath.sv]
`include "clustered_hash_table_replacement_defines.svh"

module chtr_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  chtr_pkg::cmd_t                         cmd,
    output chtr_pkg::status_t                      status,
    input  logic                                   func,
    input  logic [chtr_pkg::KEY_W-1:0]             key,
    input  logic signed [chtr_pkg::DEPTH_W-1:0]    depth,
    input  logic signed [chtr_pkg::VALUE_W-1:0]    value,
    input  logic signed [chtr_pkg::EVAL_W-1:0]     eval,
    input  logic [chtr_pkg::MOVE_W-1:0]            move,
    input  logic [chtr_pkg::BOUND_W-1:0]           bound,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [chtr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [chtr_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   hit,
    output logic [chtr_pkg::MOVE_W-1:0]            found_move,
    output logic signed [chtr_pkg::VALUE_W-1:0]    found_value,
    output logic signed [chtr_pkg::EVAL_W-1:0]     found_eval,
    output logic signed [chtr_pkg::DEPTH_W-1:0]    found_depth,
    output logic [chtr_pkg::BOUND_W-1:0]           found_bound
);

    logic [chtr_pkg::ROW_W-1:0] mem [chtr_pkg::MAX_CLUSTERS];

    logic [chtr_pkg::CC_W-1:0]      cluster_count_reg;
    logic [chtr_pkg::GEN_W-1:0]     generation_reg;
    logic [chtr_pkg::CLUSTER_W-1:0] clear_addr_reg;
    logic                           out_valid_reg;

    logic                            func_reg;
    logic [chtr_pkg::KEY_W-1:0]      key_reg;
    logic [chtr_pkg::DEPTH_W-1:0]    depth_reg;
    logic [chtr_pkg::VALUE_W-1:0]    value_reg;
    logic [chtr_pkg::EVAL_W-1:0]     eval_reg;
    logic [chtr_pkg::MOVE_W-1:0]     move_reg;
    logic [chtr_pkg::BOUND_W-1:0]    bound_reg;
    logic [chtr_pkg::MUL_W-1:0]      hi_reg;
    logic [chtr_pkg::CC_W-1:0]       lo_top_reg;
    logic [chtr_pkg::CLUSTER_W-1:0]  idx_reg;
    logic [chtr_pkg::ROW_W-1:0]      row_reg;

    logic                            hit_reg;
    logic [chtr_pkg::DATA_W-1:0]     found_reg;

    logic [chtr_pkg::MUL_W-1:0]      lo_prod;
    logic [chtr_pkg::SUM_W-1:0]      idx_sum;
    logic [chtr_pkg::CLUSTER_W-1:0]  idx_next;
    logic [chtr_pkg::CC_W-1:0]       cc_write;

    logic [chtr_pkg::DATA_W-1:0]        way_data  [chtr_pkg::WAYS];
    logic [chtr_pkg::KEY_W-1:0]         way_key   [chtr_pkg::WAYS];
    logic [chtr_pkg::WAYS-1:0]          way_match;
    logic [chtr_pkg::WAYS-1:0]          way_free;
    logic signed [chtr_pkg::WORTH_W-1:0] way_worth [chtr_pkg::WAYS];

    logic                           hit_any;
    logic [chtr_pkg::DATA_W-1:0]    hit_data;
    logic [chtr_pkg::WAY_W-1:0]     rep;
    logic                           rep_found;
    logic [chtr_pkg::DATA_W-1:0]    rep_data;
    logic [chtr_pkg::MOVE_W-1:0]    new_move;
    logic [chtr_pkg::DATA_W-1:0]    new_data;
    logic [chtr_pkg::KEY_W-1:0]     new_key;
    logic [chtr_pkg::ROW_W-1:0]     row_new;

    assign cfg_ready = 1'b1;

    assign status.clear_last = (clear_addr_reg == chtr_pkg::CLUSTER_W'(chtr_pkg::MAX_CLUSTERS - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign cc_write = (cfg_data > chtr_pkg::CC_LIMIT) ? chtr_pkg::CC_LIMIT : cfg_data;

    assign lo_prod  = chtr_pkg::MUL_W'(key[chtr_pkg::HALF_W-1:0])
                    * chtr_pkg::MUL_W'(cluster_count_reg);
    assign idx_sum  = chtr_pkg::SUM_W'(hi_reg) + chtr_pkg::SUM_W'(lo_top_reg);
    assign idx_next = chtr_pkg::CLUSTER_W'(idx_sum >> chtr_pkg::HALF_W);

    always_comb
    begin
        for (int w = 0; w < chtr_pkg::WAYS; w++)
        begin
            way_data[w]  = row_reg[w*chtr_pkg::ENTRY_W +: chtr_pkg::DATA_W];
            way_key[w]   = row_reg[w*chtr_pkg::ENTRY_W + chtr_pkg::DATA_W +: chtr_pkg::KEY_W]
                         ^ way_data[w];
            way_match[w] = (way_data[w] != '0) && (way_key[w] == key_reg);
            way_free[w]  = (way_data[w] == '0) || way_match[w];
            way_worth[w] = chtr_pkg::entry_worth(way_data[w], generation_reg);
        end
    end

    // The first empty or matching way wins; otherwise the least worth, earlier way on a tie.
    always_comb
    begin
        hit_any   = 1'b0;
        hit_data  = '0;
        rep       = '0;
        rep_found = 1'b0;
        for (int w = 0; w < chtr_pkg::WAYS; w++)
        begin
            if (way_match[w] && !hit_any)
            begin
                hit_any  = 1'b1;
                hit_data = way_data[w];
            end
            if (!rep_found)
            begin
                if (way_free[w])
                begin
                    rep       = chtr_pkg::WAY_W'(w);
                    rep_found = 1'b1;
                end
                else if (way_worth[w] < way_worth[rep])
                begin
                    rep = chtr_pkg::WAY_W'(w);
                end
            end
        end
    end

    always_comb
    begin
        rep_data = way_data[rep];
        if ((move_reg == '0) && way_match[rep])
        begin
            new_move = rep_data[chtr_pkg::MOVE_LSB +: chtr_pkg::MOVE_W];
        end
        else
        begin
            new_move = move_reg;
        end
        new_data = {generation_reg, bound_reg, depth_reg, eval_reg, value_reg, new_move};
        new_key  = key_reg ^ new_data;
        row_new  = row_reg;
        row_new[rep*chtr_pkg::ENTRY_W +: chtr_pkg::ENTRY_W] = {new_key, new_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= chtr_pkg::CC_RESET;
            generation_reg    <= '0;
            clear_addr_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    chtr_pkg::REG_CLUSTER_COUNT: cluster_count_reg <= cc_write;
                    chtr_pkg::REG_GENERATION:    generation_reg    <= cfg_data[chtr_pkg::GEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.clear_wr)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            key_reg    <= key;
            depth_reg  <= depth;
            value_reg  <= value;
            eval_reg   <= eval;
            move_reg   <= move;
            bound_reg  <= bound;
            hi_reg     <= chtr_pkg::MUL_W'(key[chtr_pkg::KEY_W-1:chtr_pkg::HALF_W])
                        * chtr_pkg::MUL_W'(cluster_count_reg);
            lo_top_reg <= lo_prod[chtr_pkg::MUL_W-1:chtr_pkg::HALF_W];
        end
        if (cmd.read)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.commit)
        begin
            if ((func_reg == chtr_pkg::FUNC_PROBE) && hit_any)
            begin
                hit_reg   <= 1'b1;
                found_reg <= hit_data;
            end
            else
            begin
                hit_reg   <= 1'b0;
                found_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (cmd.commit && (func_reg == chtr_pkg::FUNC_STORE))
        begin
            mem[idx_reg] <= row_new;
        end
        if (cmd.read)
        begin
            row_reg <= mem[idx_next];
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_move  = found_reg[15:0];
    assign found_value = signed'(found_reg[31:16]);
    assign found_eval  = signed'(found_reg[47:32]);
    assign found_depth = signed'(found_reg[55:48]);
    assign found_bound = found_reg[57:56];

    `CHTR_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_reg, "committed result not presented")
    `CHTR_ASSERT_NOW(a_clear_alone, cmd.clear_wr, !cmd.read && !cmd.commit && !cmd.capture, "table access during clearing")
    `CHTR_ASSERT_NEXT(a_store_never_hits, cmd.commit && (func_reg == chtr_pkg::FUNC_STORE), !hit_reg, "store reported a hit")

endmodule
